// ----- hdl/feedback_echo_delay_top_assert.svh -----
`ifndef FEEDBACK_ECHO_DELAY_TOP_ASSERT_SVH
`define FEEDBACK_ECHO_DELAY_TOP_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define FED_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define FED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/fed_pkg.sv -----
package fed_pkg;

  localparam int DEPTH      = 4096;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int SAMPLE_W   = 16;
  localparam int DELAY_W    = 13;
  localparam int FB_W       = 17;
  localparam int GAIN_W     = 16;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CALC_W     = DELAY_W + 1;

  localparam int FB_SHIFT   = 16;
  localparam int G_SHIFT    = 12;
  localparam int FB_PROD_W  = SAMPLE_W + FB_W + 1;
  localparam int G_PROD_W   = SAMPLE_W + GAIN_W;
  localparam int SUM_W      = G_PROD_W - G_SHIFT + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [DELAY_W-1:0]         DEPTH_D    = DELAY_W'(DEPTH);
  localparam logic [FB_W-1:0]            FB_ONE     = FB_W'(1 << FB_SHIFT);
  localparam logic signed [GAIN_W-1:0]   GAIN_RESET = GAIN_W'(4096);
  localparam logic signed [FB_PROD_W-1:0] FB_HALF   = FB_PROD_W'(1 << (FB_SHIFT - 1));
  localparam logic signed [G_PROD_W-1:0]  G_HALF    = G_PROD_W'(1 << (G_SHIFT - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_DELAY    = 2'd1,
    CFG_FEEDBACK = 2'd2,
    CFG_WET_GAIN = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } out_word_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return SAMPLE_W'(hi);
    end else if (v < lo) begin
      return SAMPLE_W'(lo);
    end
    return SAMPLE_W'(v);
  endfunction

endpackage

// ----- hdl/fed_stream_if.sv -----
interface fed_in_if import fed_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       block_last;

  modport source (output valid, output sample_in, output block_last, input ready);
  modport sink (input valid, input sample_in, input block_last, output ready);
endinterface

interface fed_out_if import fed_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       last_out;

  modport source (output valid, output sample_out, output last_out, input ready);
  modport sink (input valid, input sample_out, input last_out, output ready);
endinterface

// ----- hdl/fed_ram.sv -----
module fed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/feedback_echo_delay_top.sv -----
// Channel   Port      Direction  Words
// input     in_if_i   sink       sample_in, block_last
// output    out_if_o  source     sample_out, last_out
//
// One word is accepted per cycle while ready; each result passes s1, s2 and the output queue.
// Each word takes one read of the single delay memory and, while active, one write, so one
// memory port pair sets the rate.
// The memory is not cleared after reset; a fill mark tracks which entries were written, and
// unwritten ones read as zero, so words are accepted from the first cycle after reset.
// A four-word output queue absorbs stalls; the input stalls only when that queue and the two
// pipeline stages hold four words.
module feedback_echo_delay_top import fed_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  fed_in_if.sink                 in_if_i,
  fed_out_if.source              out_if_o
);

  logic                       enable_q;
  logic [DELAY_W-1:0]         delay_q;
  logic [FB_W-1:0]            fb_q;
  logic signed [GAIN_W-1:0]   gain_q;

  logic [ADDR_W-1:0]          wp_q;
  logic                       wrapped_q;

  logic                       in_fire;
  logic                       act;
  logic [DELAY_W-1:0]         d_eff;
  logic [CALC_W-1:0]          wp_ext;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       entry_ok;

  logic                       s1_v_q;
  logic                       s1_act_q;
  logic                       s1_ok_q;
  logic [ADDR_W-1:0]          s1_rd_q;
  logic [ADDR_W-1:0]          s1_wa_q;
  logic signed [SAMPLE_W-1:0] s1_x_q;
  logic                       s1_last_q;
  logic signed [SAMPLE_W-1:0] s1_dl;
  logic [SAMPLE_W-1:0]        ram_rdata;

  logic                       s2_v_q;
  logic                       s2_act_q;
  logic [ADDR_W-1:0]          s2_wa_q;
  logic signed [SAMPLE_W-1:0] s2_x_q;
  logic                       s2_last_q;
  logic signed [SAMPLE_W-1:0] s2_dl_q;

  logic [FB_W-1:0]             fb_eff;
  logic signed [FB_PROD_W-1:0] prod_fb;
  logic signed [FB_PROD_W-1:0] fb_r;
  logic signed [G_PROD_W-1:0]  prod_g;
  logic signed [G_PROD_W-1:0]  g_r;
  logic signed [SUM_W-1:0]     wsum;
  logic signed [SUM_W-1:0]     ysum;
  logic signed [SAMPLE_W-1:0]  wr_data;
  logic signed [SAMPLE_W-1:0]  y;
  logic                        mem_we;

  logic                       lw_v_q;
  logic [ADDR_W-1:0]          lw_addr_q;
  logic signed [SAMPLE_W-1:0] lw_data_q;

  out_word_t                  fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]         fifo_wp_q;
  logic [FIFO_AW-1:0]         fifo_rp_q;
  logic [FIFO_CW-1:0]         fifo_cnt_q;
  logic                       out_fire;
  logic [FIFO_CW-1:0]         occupancy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      delay_q  <= '0;
      fb_q     <= '0;
      gain_q   <= GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:   enable_q <= cfg_data_i[0];
        CFG_DELAY:    delay_q  <= cfg_data_i[DELAY_W-1:0];
        CFG_FEEDBACK: fb_q     <= cfg_data_i[FB_W-1:0];
        CFG_WET_GAIN: gain_q   <= cfg_data_i[GAIN_W-1:0];
        default:      ;
      endcase
    end
  end

  assign occupancy     = fifo_cnt_q + FIFO_CW'(s1_v_q) + FIFO_CW'(s2_v_q);
  assign in_if_i.ready = (occupancy < FIFO_CW'(FIFO_DEPTH));
  assign in_fire       = in_if_i.valid && in_if_i.ready;

  assign act    = enable_q && (delay_q != '0);
  assign d_eff  = (delay_q > DEPTH_D) ? DEPTH_D : delay_q;
  assign wp_ext = CALC_W'(wp_q);

  always_comb begin
    if (wp_ext >= CALC_W'(d_eff)) begin
      rd_addr = ADDR_W'(wp_ext - CALC_W'(d_eff));
    end else begin
      rd_addr = ADDR_W'(wp_ext + CALC_W'(DEPTH_D) - CALC_W'(d_eff));
    end
  end

  // Entries are filled in pointer order, so an entry below the pointer or any entry after
  // the first wrap holds written data.
  assign entry_ok = wrapped_q || (rd_addr < wp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (in_fire && act) begin
      if (wp_q == ADDR_W'(DEPTH - 1)) begin
        wp_q      <= '0;
        wrapped_q <= 1'b1;
      end else begin
        wp_q <= wp_q + ADDR_W'(1);
      end
    end
  end

  fed_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (s2_wa_q),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_act_q  <= act;
      s1_ok_q   <= entry_ok;
      s1_rd_q   <= rd_addr;
      s1_wa_q   <= wp_q;
      s1_x_q    <= in_if_i.sample_in;
      s1_last_q <= in_if_i.block_last;
    end
  end

  // Writes still in the pipeline or landing on the read edge are forwarded, newest first.
  always_comb begin
    priority if (s2_v_q && s2_act_q && (s2_wa_q == s1_rd_q)) begin
      s1_dl = wr_data;
    end else if (lw_v_q && (lw_addr_q == s1_rd_q)) begin
      s1_dl = lw_data_q;
    end else if (s1_ok_q) begin
      s1_dl = $signed(ram_rdata);
    end else begin
      s1_dl = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_act_q  <= s1_act_q;
      s2_wa_q   <= s1_wa_q;
      s2_x_q    <= s1_x_q;
      s2_last_q <= s1_last_q;
      s2_dl_q   <= s1_dl;
    end
  end

  assign fb_eff  = (fb_q > FB_ONE) ? FB_ONE : fb_q;
  assign prod_fb = FB_PROD_W'(s2_dl_q) * FB_PROD_W'($signed({1'b0, fb_eff}));
  assign fb_r    = prod_fb + FB_HALF;
  assign prod_g  = G_PROD_W'(s2_dl_q) * G_PROD_W'(gain_q);
  assign g_r     = prod_g + G_HALF;
  assign wsum    = SUM_W'(s2_x_q) + SUM_W'($signed(fb_r[FB_PROD_W-1:FB_SHIFT]));
  assign ysum    = SUM_W'(s2_x_q) + SUM_W'($signed(g_r[G_PROD_W-1:G_SHIFT]));
  assign wr_data = sat_sample(wsum);
  assign y       = s2_act_q ? sat_sample(ysum) : s2_x_q;
  assign mem_we  = s2_v_q && s2_act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_v_q <= 1'b0;
    end else if (mem_we) begin
      lw_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lw_addr_q <= s2_wa_q;
      lw_data_q <= wr_data;
    end
  end

  assign out_fire = out_if_o.valid && out_if_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wp_q  <= '0;
      fifo_rp_q  <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (s2_v_q) begin
        fifo_wp_q <= fifo_wp_q + FIFO_AW'(1);
      end
      if (out_fire) begin
        fifo_rp_q <= fifo_rp_q + FIFO_AW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + FIFO_CW'(s2_v_q) - FIFO_CW'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      fifo_q[fifo_wp_q] <= '{sample: y, last: s2_last_q};
    end
  end

  assign out_if_o.valid      = (fifo_cnt_q != '0);
  assign out_if_o.sample_out = fifo_q[fifo_rp_q].sample;
  assign out_if_o.last_out   = fifo_q[fifo_rp_q].last;

endmodule

// ----- hdl/fed_checker.sv -----
`include "feedback_echo_delay_top_assert.svh"

module fed_checker import fed_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic signed [SAMPLE_W-1:0] sample_out_i,
  input logic                       last_out_i
);

  logic [FIFO_CW-1:0] pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + FIFO_CW'(in_valid_i && in_ready_i)
                   - FIFO_CW'(out_valid_i && out_ready_i);
    end
  end

  `FED_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(sample_out_i) && $stable(last_out_i), "stalled output word changed")
  `FED_ASSERT_NOW(a_out_has_word, clk_i, rst_ni, out_valid_i, pending_q != '0,
    "output word without an accepted input word")
  `FED_ASSERT_NOW(a_idle_ready, clk_i, rst_ni, pending_q == '0, in_ready_i,
    "empty block refuses input")
  `FED_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready_i,
    out_valid_i && (pending_q <= FIFO_CW'(FIFO_DEPTH)), "input stalled without a waiting result")

endmodule

bind feedback_echo_delay_top fed_checker u_fed_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if_i.valid),
  .in_ready_i   (in_if_i.ready),
  .out_valid_i  (out_if_o.valid),
  .out_ready_i  (out_if_o.ready),
  .sample_out_i (out_if_o.sample_out),
  .last_out_i   (out_if_o.last_out)
);
